// File: design/kbs_pkg.sv
// package for the keyboard buffer service block
// types, service codes and constants shared by kbs_ctrl, kbs_dp and the top level
// no dependencies
`timescale 1ns / 1ps

package kbs_pkg;

  localparam int unsigned RING_DEPTH_DEF = 16;

  localparam logic [15:0] START_OFF_RST = 16'd30;
  localparam logic [15:0] END_OFF_RST   = 16'd62;

  // service codes (AH of the call)
  localparam logic [7:0] FN_READ      = 8'h00;
  localparam logic [7:0] FN_READ_EXT  = 8'h10;
  localparam logic [7:0] FN_CHECK     = 8'h01;
  localparam logic [7:0] FN_CHECK_EXT = 8'h11;
  localparam logic [7:0] FN_SHIFT     = 8'h02;
  localparam logic [7:0] FN_STORE     = 8'h05;
  localparam logic [7:0] FN_STORE_ALT = 8'hFF;
  localparam logic [7:0] FN_CAPS      = 8'h09;
  localparam logic [7:0] FN_KBD_ID    = 8'h0A;
  localparam logic [7:0] FN_SHIFT_EXT = 8'h12;
  localparam logic [7:0] FN_EXT_AH    = 8'h92;

  // ax write modes
  localparam logic [1:0] AXW_NONE = 2'd0;
  localparam logic [1:0] AXW_AX   = 2'd1;
  localparam logic [1:0] AXW_AL   = 2'd2;
  localparam logic [1:0] AXW_AH   = 2'd3;

  // reply constants
  localparam logic [7:0]  CAPS_VAL       = 8'h30;
  localparam logic [15:0] KBD_ID_VAL     = 16'hAB83;
  localparam logic [7:0]  EXT_AH_VAL     = 8'h80;
  localparam logic [7:0]  RCTRL_ALT_MASK = 8'h0C;

  // configuration register indexes
  localparam logic REG_START_OFF = 1'b0;
  localparam logic REG_END_OFF   = 1'b1;

  typedef struct packed {
    logic [7:0]  func;
    logic [15:0] key_word;
    logic [7:0]  shift_flags_main;
    logic [7:0]  shift_flags_second;
    logic [7:0]  shift_flags_extended;
  } kbs_in_t;

  typedef struct packed {
    logic        completed;
    logic [1:0]  ax_write_mode;
    logic [15:0] ax_result;
    logic        bx_write;
    logic [15:0] bx_result;
    logic        zero_flag_write;
    logic        zero_flag_value;
    logic        carry_clear;
  } kbs_out_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ADDR = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_MOD  = 6'b001000,
    ST_READ = 6'b010000,
    ST_EXEC = 6'b100000
  } kbs_state_t;

  typedef struct packed {
    logic capture;
    logic addr;
    logic mul;
    logic modr;
    logic rd;
    logic exec;
  } kbs_cmd_t;

endpackage

// File: design/kbs_ctrl.sv
// sequencer for the keyboard buffer service block
// steps one item through address, slot and ring access phases; uses kbs_pkg
`timescale 1ns / 1ps

module kbs_ctrl import kbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output kbs_cmd_t cmd
);

  kbs_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_ADDR;
      end
      ST_ADDR: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign cmd.capture = (state_r == ST_IDLE) && start;
  assign cmd.addr    = (state_r == ST_ADDR);
  assign cmd.mul     = (state_r == ST_MUL);
  assign cmd.modr    = (state_r == ST_MOD);
  assign cmd.rd      = (state_r == ST_READ);
  assign cmd.exec    = (state_r == ST_EXEC);

endmodule

// File: design/kbs_dp.sv
// datapath for the keyboard buffer service block
// holds the key ring memory, head/tail offsets, slot arithmetic and result register; uses kbs_pkg
`timescale 1ns / 1ps

module kbs_dp import kbs_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  kbs_cmd_t    cmd,
  input  kbs_in_t     in_item,
  input  logic [15:0] start_off,
  input  logic [15:0] end_off,
  output logic        out_valid,
  output kbs_out_t    out_item
);

  localparam int unsigned SLOT_W = $clog2(RING_DEPTH);
  // reciprocal for an exact 15-bit quotient by the ring depth
  localparam int unsigned RECIP_SH = 15 + $clog2(RING_DEPTH);
  localparam logic [16:0] RECIP =
    17'(((64'd1 << RECIP_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));
  localparam logic [15:0] DEPTH_16 = 16'(RING_DEPTH);
  localparam logic [23:0] DEPTH_24 = 24'(RING_DEPTH);
  localparam logic [16:0] SPAN_MAX = 17'(2 * RING_DEPTH);

  logic [15:0] ring_mem [RING_DEPTH];

  kbs_in_t     in_r;
  logic [15:0] head_r, tail_r;
  logic [14:0] xh_r, xt_r;
  logic [15:0] adv_h_r, adv_t_r;
  logic [14:0] qh_r, qt_r;
  logic [15:0] rh_r, rt_r;
  logic [SLOT_W-1:0] tail_slot_r;
  logic [15:0] rd_data_r;
  logic        out_valid_r;
  kbs_out_t    out_item_r;

  logic [15:0] span;
  logic [16:0] eff_end;
  logic [31:0] prod_h, prod_t;
  logic [23:0] qd_h, qd_t;
  logic [15:0] hs, ts;
  logic [SLOT_W-1:0] head_slot;
  logic        empty, full, is_store, is_read;
  kbs_out_t    res;

  function automatic logic [15:0] advance(input logic [15:0] p, input logic [16:0] lim,
                                          input logic [15:0] base);
    logic [16:0] n;
    n = {1'b0, p} + 17'd2;
    if (n >= lim) return base;
    return n[15:0];
  endfunction

  assign span    = end_off - start_off;
  assign eff_end = ({1'b0, span} > SPAN_MAX) ? ({1'b0, start_off} + SPAN_MAX)
                                             : {1'b0, end_off};

  assign prod_h = {17'b0, xh_r} * {15'b0, RECIP};
  assign prod_t = {17'b0, xt_r} * {15'b0, RECIP};
  assign qd_h   = {9'b0, qh_r} * DEPTH_24;
  assign qd_t   = {9'b0, qt_r} * DEPTH_24;

  // one compare and subtract finishes the remainder
  assign hs        = (rh_r >= DEPTH_16) ? (rh_r - DEPTH_16) : rh_r;
  assign ts        = (rt_r >= DEPTH_16) ? (rt_r - DEPTH_16) : rt_r;
  assign head_slot = hs[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_item;
    if (cmd.addr) begin
      xh_r    <= 15'((head_r - start_off) >> 1);
      xt_r    <= 15'((tail_r - start_off) >> 1);
      adv_h_r <= advance(head_r, eff_end, start_off);
      adv_t_r <= advance(tail_r, eff_end, start_off);
    end
    if (cmd.mul) begin
      qh_r <= 15'(prod_h >> RECIP_SH);
      qt_r <= 15'(prod_t >> RECIP_SH);
    end
    if (cmd.modr) begin
      rh_r <= {1'b0, xh_r} - qd_h[15:0];
      rt_r <= {1'b0, xt_r} - qd_t[15:0];
    end
    if (cmd.rd) begin
      rd_data_r   <= ring_mem[head_slot];
      tail_slot_r <= ts[SLOT_W-1:0];
    end
    if (cmd.exec && is_store && !full) ring_mem[tail_slot_r] <= in_r.key_word;
    if (cmd.exec) out_item_r <= res;
  end

  assign empty    = (head_r == tail_r);
  assign full     = (adv_t_r == head_r);
  assign is_store = (in_r.func == FN_STORE) || (in_r.func == FN_STORE_ALT);
  assign is_read  = (in_r.func == FN_READ) || (in_r.func == FN_READ_EXT);

  always_comb begin
    res = '0;
    res.completed = 1'b1;
    case (in_r.func)
      FN_READ, FN_READ_EXT: begin
        if (empty) begin
          res.completed = 1'b0;
        end else begin
          res.ax_write_mode = AXW_AX;
          res.ax_result     = rd_data_r;
        end
      end
      FN_CHECK, FN_CHECK_EXT: begin
        res.carry_clear     = 1'b1;
        res.zero_flag_write = 1'b1;
        if (empty) begin
          res.zero_flag_value = 1'b1;
        end else begin
          res.ax_write_mode = AXW_AX;
          res.ax_result     = rd_data_r;
        end
      end
      FN_SHIFT: begin
        res.ax_write_mode = AXW_AL;
        res.ax_result     = {8'h00, in_r.shift_flags_main};
      end
      FN_STORE: begin
        res.ax_write_mode = AXW_AL;
        res.ax_result     = {15'b0, full};
      end
      FN_STORE_ALT: begin
        res.ax_write_mode = AXW_AL;
        res.ax_result     = {15'b0, full};
        res.carry_clear   = 1'b1;
      end
      FN_CAPS: begin
        res.ax_write_mode = AXW_AL;
        res.ax_result     = {8'h00, CAPS_VAL};
      end
      FN_KBD_ID: begin
        res.bx_write  = 1'b1;
        res.bx_result = KBD_ID_VAL;
      end
      FN_SHIFT_EXT: begin
        // right ctrl/alt bits come from the extended byte
        res.ax_write_mode = AXW_AX;
        res.ax_result     = {(in_r.shift_flags_second & ~RCTRL_ALT_MASK) |
                             (in_r.shift_flags_extended & RCTRL_ALT_MASK),
                             in_r.shift_flags_main};
      end
      FN_EXT_AH: begin
        res.ax_write_mode = AXW_AH;
        res.ax_result     = {EXT_AH_VAL, 8'h00};
      end
      default: begin
        res.completed = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= START_OFF_RST;
      tail_r      <= START_OFF_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      if (cmd.exec && is_read && !empty) head_r <= adv_h_r;
      if (cmd.exec && is_store && !full) tail_r <= adv_t_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: design/keyboard_buffer_service.sv
// top level of the keyboard buffer service block: configuration registers and
// the kbs_ctrl sequencer joined to the kbs_dp datapath; uses kbs_pkg
//
//  channel   handshake                      payload
//  input     start / busy                   in_item   (kbs_in_t)
//  result    out_valid strobe, one cycle    out_item  (kbs_out_t)
//  config    psel penable pwrite pready     paddr, pwdata / prdata
//
// one item at a time, a new one taken only while busy is low: accept, pointer
// advance, reciprocal multiply, remainder, registered ring read, then execute
// result strobes in the cycle after execute, when busy has already dropped
// reset (rst_n low, synchronous) empties the ring and restores offsets 30 and 62
// results cannot be stalled; the strobe is never repeated
`timescale 1ns / 1ps

module keyboard_buffer_service import kbs_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  kbs_in_t     in_item,
  output logic        out_valid,
  output kbs_out_t    out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] start_off_r, end_off_r;
  logic        cfg_wr;
  kbs_cmd_t    cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_off_r <= START_OFF_RST;
      end_off_r   <= END_OFF_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_START_OFF) start_off_r <= pwdata[15:0];
      if (paddr[2] == REG_END_OFF)   end_off_r   <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_END_OFF) ? {16'h0000, end_off_r} : {16'h0000, start_off_r};

  kbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  kbs_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .start_off (start_off_r),
    .end_off   (end_off_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while the sequencer is still busy");

endmodule
